// ----- rtl/mwm_pkg.sv -----
// Shared constants, types and sine/cosine table functions for the mecanum wheel mixer.
package mwm_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int TRIG_BITS_DEF  = 15;
  localparam int TRIG_MAX_BITS  = 24;

  localparam logic [1:0] MODE_ZERO_FORCE = 2'd0;
  localparam logic [1:0] MODE_NO_FOLLOW  = 2'd1;
  localparam logic [1:0] MODE_FOLLOW_YAW = 2'd2;
  localparam logic [1:0] MODE_SPIN       = 2'd3;

  localparam logic CFG_SPIN_SPEED = 1'b0;
  localparam logic CFG_POWER_GAIN = 1'b1;

  localparam logic [14:0] SPIN_SPEED_RST = 15'd2000;
  localparam logic [9:0]  POWER_GAIN_RST = 10'd384;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef struct packed {
    logic valid;
    logic motors_en;
  } mwm_ctl_t;

  function automatic longint q30_mul(longint a, longint b);
    return (a * b) / Q30_ONE;
  endfunction

  function automatic longint to_trig(longint v, int trig_bits);
    longint q;
    q = v;
    if (q < 0) q = 0;
    if (q > Q30_ONE) q = Q30_ONE;
    return (q + (longint'(1) << (29 - trig_bits))) >> (30 - trig_bits);
  endfunction

  // {sin, cos} for first-quadrant index idx, each TRIG_MAX_BITS+1 bits, Q.trig_bits
  function automatic logic [2*TRIG_MAX_BITS+1:0] trig_entry(int angle_bits, int trig_bits,
                                                             longint idx);
    longint r;
    longint x;
    longint x2;
    longint t;
    longint s;
    longint c;
    r  = idx << (32 - angle_bits);
    x  = (r * HALF_PI_Q30) / Q30_ONE;
    x2 = q30_mul(x, x);
    t = Q30_ONE;
    t = Q30_ONE - q30_mul(x2, t) / 110;
    t = Q30_ONE - q30_mul(x2, t) / 72;
    t = Q30_ONE - q30_mul(x2, t) / 42;
    t = Q30_ONE - q30_mul(x2, t) / 20;
    t = Q30_ONE - q30_mul(x2, t) / 6;
    s = to_trig(q30_mul(x, t), trig_bits);
    t = Q30_ONE;
    t = Q30_ONE - q30_mul(x2, t) / 132;
    t = Q30_ONE - q30_mul(x2, t) / 90;
    t = Q30_ONE - q30_mul(x2, t) / 56;
    t = Q30_ONE - q30_mul(x2, t) / 30;
    t = Q30_ONE - q30_mul(x2, t) / 12;
    t = Q30_ONE - q30_mul(x2, t) / 2;
    c = to_trig(t, trig_bits);
    return {s[TRIG_MAX_BITS:0], c[TRIG_MAX_BITS:0]};
  endfunction

endpackage

// ----- rtl/mwm_trig_rom.sv -----
// First-quadrant sine/cosine ROM with registered read.
module mwm_trig_rom #(
  parameter int ANGLE_BITS = mwm_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_BITS  = mwm_pkg::TRIG_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [ANGLE_BITS-3:0]      rd_addr,
  output logic [2*TRIG_BITS+1:0]     rd_data   // {sin, cos}
);
  import mwm_pkg::*;

  localparam int DEPTH = 2 ** (ANGLE_BITS - 2);
  localparam int W     = 2 * (TRIG_BITS + 1);

  logic [W-1:0] rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam logic [2*TRIG_MAX_BITS+1:0] ENT =
      trig_entry(ANGLE_BITS, TRIG_BITS, longint'(i));
    assign rom[i] = {ENT[TRIG_MAX_BITS+1 +: TRIG_BITS+1], ENT[0 +: TRIG_BITS+1]};
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rom[rd_addr];
    end
  end

endmodule

// ----- rtl/mwm_rotate.sv -----
// Quadrant unfold, frame rotation products and wheel mixing sums (two stages).
module mwm_rotate #(
  parameter int TRIG_BITS = mwm_pkg::TRIG_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mwm_pkg::mwm_ctl_t                   in_ctl,
  output logic                                in_ready,
  input  logic [1:0]                          quad,
  input  logic signed [15:0]                  vel_x,
  input  logic signed [15:0]                  vel_y,
  input  logic signed [15:0]                  rot,
  input  logic [TRIG_BITS:0]                  sin_q,
  input  logic [TRIG_BITS:0]                  cos_q,
  output mwm_pkg::mwm_ctl_t                   out_ctl,
  input  logic                                out_ready,
  output logic signed [TRIG_BITS+18:0]        sums [4]  // lf, rf, lb, rb
);
  import mwm_pkg::*;

  localparam int TW = TRIG_BITS + 2;
  localparam int PW = 16 + TW;
  localparam int SW = TRIG_BITS + 19;

  logic signed [TW-1:0] s_u, c_u, s_q, c_q;
  logic                 ready2, ready3;

  mwm_ctl_t             ctl2;
  logic signed [PW-1:0] pxc, pys, pxs, pyc;
  logic signed [15:0]   rot2;

  logic signed [SW-1:0] cx, cy, ws;

  assign s_u = $signed({1'b0, sin_q});
  assign c_u = $signed({1'b0, cos_q});

  always_comb begin
    unique case (quad)
      2'd0: begin s_q = s_u;  c_q = c_u;  end
      2'd1: begin s_q = c_u;  c_q = -s_u; end
      2'd2: begin s_q = -s_u; c_q = -c_u; end
      default: begin s_q = -c_u; c_q = s_u; end
    endcase
  end

  assign ready3   = !out_ctl.valid || out_ready;
  assign ready2   = !ctl2.valid || ready3;
  assign in_ready = ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else if (ready2) begin
      ctl2 <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      pxc  <= PW'(vel_x) * PW'(c_q);
      pys  <= PW'(vel_y) * PW'(s_q);
      pxs  <= PW'(vel_x) * PW'(s_q);
      pyc  <= PW'(vel_y) * PW'(c_q);
      rot2 <= rot;
    end
  end

  assign cx = SW'(pxc) - SW'(pys);
  assign cy = SW'(pxs) + SW'(pyc);
  assign ws = SW'(rot2) <<< TRIG_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (ready3) begin
      out_ctl <= ctl2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      sums[0] <= cx - cy - ws;
      sums[1] <= cx + cy + ws;
      sums[2] <= cx + cy - ws;
      sums[3] <= cx - cy + ws;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    ctl2.valid && !ready3 |=> ctl2.valid && $stable(pxc) && $stable(pys))
    else $error("stage two lost its products under stall");

endmodule

// ----- rtl/mwm_scale.sv -----
// Gain multiply, round-to-nearest and signed 16-bit saturation, output register.
module mwm_scale #(
  parameter int TRIG_BITS = mwm_pkg::TRIG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mwm_pkg::mwm_ctl_t             in_ctl,
  output logic                          in_ready,
  input  logic signed [TRIG_BITS+18:0]  sums [4],
  input  logic [9:0]                    power_gain,
  output mwm_pkg::mwm_ctl_t             out_ctl,
  input  logic                          out_ready,
  output logic signed [15:0]            wheels [4]
);
  import mwm_pkg::*;

  localparam int SW = TRIG_BITS + 19;
  localparam int PW = SW + 11;
  localparam int N  = TRIG_BITS + 8;

  mwm_ctl_t             ctl4;
  logic                 ready4, ready5;
  logic signed [PW-1:0] prod [4];
  logic signed [PW-1:0] rnd  [4];
  logic signed [PW-1:0] shr  [4];
  logic signed [15:0]   sat  [4];

  assign ready5   = !out_ctl.valid || out_ready;
  assign ready4   = !ctl4.valid || ready5;
  assign in_ready = ready4;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4 <= '0;
    end else if (ready4) begin
      ctl4 <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      for (int i = 0; i < 4; i++) begin
        prod[i] <= PW'(sums[i]) * PW'($signed({1'b0, power_gain}));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd[i] = prod[i] + (PW'(1) <<< (N - 1));
      shr[i] = rnd[i] >>> N;
      if (shr[i] > PW'(32767)) begin
        sat[i] = 16'sd32767;
      end else if (shr[i] < -PW'(32768)) begin
        sat[i] = -16'sd32768;
      end else begin
        sat[i] = shr[i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else if (ready5) begin
      out_ctl <= ctl4;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5) begin
      for (int i = 0; i < 4; i++) begin
        wheels[i] <= sat[i];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    ctl4.valid && !ready5 |=> ctl4.valid && $stable(prod[0]) && $stable(prod[3]))
    else $error("stage four lost its products under stall");

endmodule

// ----- rtl/mecanum_wheel_mixer_top.sv -----
// Mecanum wheel mixer top level: input stage, trig ROM, rotation and scaling pipeline.
// Pipeline: an accepted input beat passes 5 register stages before its result is valid.
// Throughput: one beat per cycle; the pipeline stalls only when m_tready is low and full.
// The ROM read port and four multipliers per stage are fully pipelined.
// Reset: synchronous rst empties the pipeline and loads spin_speed 2000, power_gain 384.
module mecanum_wheel_mixer_top #(
  parameter int ANGLE_BITS = mwm_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_BITS  = mwm_pkg::TRIG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // vel_x, vel_y, rot_cmd, yaw_angle
  input  logic [1:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // wheel_lf, wheel_rf, wheel_lb, wheel_rb
  output logic [0:0]  m_tuser,   // motors_enabled
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [14:0] cfg_data
);
  import mwm_pkg::*;

  localparam int SW = TRIG_BITS + 19;

  logic [14:0] spin_speed;
  logic [9:0]  power_gain;

  logic [ANGLE_BITS-1:0] ang;
  logic signed [15:0]    rot_sel;

  mwm_ctl_t              ctl1;
  logic                  ready1, ready2;
  logic [1:0]            quad1;
  logic signed [15:0]    vx1, vy1, rot1;
  logic [2*TRIG_BITS+1:0] rom_data;

  mwm_ctl_t             ctl3, ctl5;
  logic                 ready4;
  logic signed [SW-1:0] sums [4];
  logic signed [15:0]   wheels [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      spin_speed <= SPIN_SPEED_RST;
      power_gain <= POWER_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SPIN_SPEED: spin_speed <= cfg_data;
        CFG_POWER_GAIN: power_gain <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  if (ANGLE_BITS > 16) begin : g_ang_pad
    assign ang = {s_tdata[63:48], {(ANGLE_BITS-16){1'b0}}};
  end else begin : g_ang_cut
    assign ang = s_tdata[63 -: ANGLE_BITS];
  end

  always_comb begin
    unique case (s_tuser)
      MODE_ZERO_FORCE: rot_sel = $signed(s_tdata[47:32]);
      MODE_SPIN:       rot_sel = $signed({1'b0, spin_speed});
      MODE_NO_FOLLOW,
      MODE_FOLLOW_YAW: rot_sel = 16'sd0;
      default:         rot_sel = 16'sd0;
    endcase
  end

  assign ready1   = !ctl1.valid || ready2;
  assign s_tready = ready1;

  mwm_trig_rom #(
    .ANGLE_BITS (ANGLE_BITS),
    .TRIG_BITS  (TRIG_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (ready1),
    .rd_addr (ang[ANGLE_BITS-3:0]),
    .rd_data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else if (ready1) begin
      ctl1.valid     <= s_tvalid;
      ctl1.motors_en <= (s_tuser != MODE_ZERO_FORCE);
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      quad1 <= ang[ANGLE_BITS-1 -: 2];
      vx1   <= $signed(s_tdata[15:0]);
      vy1   <= $signed(s_tdata[31:16]);
      rot1  <= rot_sel;
    end
  end

  mwm_rotate #(
    .TRIG_BITS (TRIG_BITS)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (ctl1),
    .in_ready  (ready2),
    .quad      (quad1),
    .vel_x     (vx1),
    .vel_y     (vy1),
    .rot       (rot1),
    .sin_q     (rom_data[2*TRIG_BITS+1 -: TRIG_BITS+1]),
    .cos_q     (rom_data[TRIG_BITS:0]),
    .out_ctl   (ctl3),
    .out_ready (ready4),
    .sums      (sums)
  );

  mwm_scale #(
    .TRIG_BITS (TRIG_BITS)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_ctl     (ctl3),
    .in_ready   (ready4),
    .sums       (sums),
    .power_gain (power_gain),
    .out_ctl    (ctl5),
    .out_ready  (m_tready),
    .wheels     (wheels)
  );

  assign m_tvalid   = ctl5.valid;
  assign m_tuser[0] = ctl5.motors_en;
  assign m_tdata    = {wheels[3], wheels[2], wheels[1], wheels[0]};

  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> ctl1.valid)
    else $error("accepted beat did not reach stage one");

  assert property (@(posedge clk) disable iff (rst)
    ctl1.valid && !ready2 |=> ctl1.valid && $stable(quad1) && $stable(rom_data))
    else $error("stage one or ROM output changed under stall");

  assert property (@(posedge clk)
    rst |=> !ctl1.valid && !m_tvalid)
    else $error("pipeline not empty after reset");

endmodule

// ----- test/mecanum_wheel_mixer_checker.sv -----
// Stream monitor for the mecanum wheel mixer: predicts wheel references per beat and compares.
`timescale 1ns / 1ps

module mecanum_wheel_mixer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // vel_x, vel_y, rot_cmd, yaw_angle
  input  logic [1:0]  s_tuser,   // mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // wheel_lf, wheel_rf, wheel_lb, wheel_rb
  input  logic [0:0]  m_tuser,   // motors_enabled
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [14:0] cfg_data,
  output int          mismatches,
  output int          pending
);
  import mwm_pkg::*;

  typedef struct packed {
    logic        motors_en;
    logic [63:0] wheels;     // lf, rf, lb, rb from the low bits up
  } wheel_ref_t;

  wheel_ref_t  wheel_q[$];
  logic [14:0] spin_speed;
  logic [9:0]  power_gain;
  string       wheel_name[4] = '{"wheel_lf", "wheel_rf", "wheel_lb", "wheel_rb"};

  function automatic void flag(string msg);
    if (mismatches < 10) $display("%0t: %s", $time, msg);
    mismatches++;
  endfunction

  // clamp a Q30 value to [0, 1] and round half up to Q15
  function automatic longint trig_round(longint v);
    if (v < 0) v = 0;
    else if (v > Q30_ONE) v = Q30_ONE;
    return (v + (longint'(1) <<< (29 - TRIG_BITS_DEF))) >>> (30 - TRIG_BITS_DEF);
  endfunction

  function automatic logic [15:0] gain_sat(longint v);
    longint q;
    q = (v * longint'(power_gain) + (longint'(1) <<< (TRIG_BITS_DEF + 7)))
        >>> (TRIG_BITS_DEF + 8);
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic wheel_ref_t mix_wheels(logic [1:0] mode, logic [63:0] data);
    longint     sin_div[5] = '{110, 72, 42, 20, 6};
    longint     cos_div[6] = '{132, 90, 56, 30, 12, 2};
    longint     vx, vy, w, r, x, x2, t, s0, c0, sn, cs, cx, cy;
    wheel_ref_t res;
    vx = longint'($signed(data[15:0]));
    vy = longint'($signed(data[31:16]));
    // low 30 bits of the turn phase, low 14 angle bits in the top 14 bits
    r  = longint'({data[61:48], 16'b0});
    x  = (r * HALF_PI_Q30) / Q30_ONE;
    x2 = (x * x) / Q30_ONE;
    t = Q30_ONE;
    foreach (sin_div[i]) t = Q30_ONE - ((x2 * t) / Q30_ONE) / sin_div[i];
    s0 = trig_round((x * t) / Q30_ONE);
    t = Q30_ONE;
    foreach (cos_div[i]) t = Q30_ONE - ((x2 * t) / Q30_ONE) / cos_div[i];
    c0 = trig_round(t);
    case (data[63:62])
      2'd0: begin
        sn = s0;
        cs = c0;
      end
      2'd1: begin
        sn = c0;
        cs = -s0;
      end
      2'd2: begin
        sn = -s0;
        cs = -c0;
      end
      default: begin
        sn = -c0;
        cs = s0;
      end
    endcase
    case (mode)
      MODE_ZERO_FORCE: w = longint'($signed(data[47:32]));
      MODE_SPIN:       w = longint'(spin_speed);
      default:         w = 0;
    endcase
    w  = w * (longint'(1) <<< TRIG_BITS_DEF);
    cx = vx * cs - vy * sn;
    cy = vx * sn + vy * cs;
    res.wheels = {gain_sat(cx - cy + w), gain_sat(cx + cy - w),
                  gain_sat(cx + cy + w), gain_sat(cx - cy - w)};
    res.motors_en = (mode != MODE_ZERO_FORCE);
    return res;
  endfunction

  always @(posedge clk) begin
    wheel_ref_t want;
    if (rst) begin
      wheel_q.delete();
      spin_speed <= SPIN_SPEED_RST;
      power_gain <= POWER_GAIN_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SPIN_SPEED: spin_speed <= cfg_data;
          CFG_POWER_GAIN: power_gain <= cfg_data[9:0];
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (wheel_q.size() == 0) begin
          flag($sformatf("result beat with nothing pending, data %h user %b", m_tdata, m_tuser));
        end else begin
          want = wheel_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (m_tdata[16*i +: 16] !== want.wheels[16*i +: 16])
              flag($sformatf("%s expected %0d got %0d", wheel_name[i],
                             $signed(want.wheels[16*i +: 16]), $signed(m_tdata[16*i +: 16])));
          end
          if (m_tuser[0] !== want.motors_en)
            flag($sformatf("motors_enabled expected %b got %b", want.motors_en, m_tuser[0]));
        end
      end
      if (s_tvalid && s_tready) wheel_q.push_back(mix_wheels(s_tuser, s_tdata));
    end
    pending = wheel_q.size();
  end

endmodule

// ----- test/mecanum_wheel_mixer_top_tb.sv -----
// Testbench top for the mecanum wheel mixer: clock, reset, command stimulus, flow control, verdict.
`timescale 1ns / 1ps

module mecanum_wheel_mixer_top_tb;
  import mwm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SEGMENT_ITEMS  = 323;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we;
  logic        cfg_addr;
  logic [14:0] cfg_data;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_cycles;
  int          mismatches;
  int          pending;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mecanum_wheel_mixer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  mecanum_wheel_mixer_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_cmd(logic [1:0] mode, logic [15:0] vx, logic [15:0] vy,
                          logic [15:0] rot, logic [15:0] ang);
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ang, rot, vy, vx};
    s_tuser  <= mode;
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_vel();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      2: return 16'($urandom_range(1000) - 500);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [15:0] ang;
    case ($urandom_range(2))
      0: ang = 16'($urandom);
      // near a quadrant boundary
      1: ang = 16'($urandom_range(3) * 16384 + $urandom_range(8) - 4);
      default: ang = 16'($urandom_range(65535));
    endcase
    send_cmd(2'($urandom_range(3)), pick_vel(), pick_vel(), pick_vel(), ang);
  endtask

  // hold off the sender until every result beat is back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [14:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    cfg_we        = 1'b0;
    cfg_addr      = 1'b0;
    cfg_data      = '0;
    send_idle_pct = 35;
    recv_idle_pct = 84;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every mode, quadrant edges, zero force with rotation
    send_cmd(MODE_NO_FOLLOW,  16'h7FFF, 16'h0000, 16'h0000, 16'd0);
    send_cmd(MODE_NO_FOLLOW,  16'h8000, 16'h8000, 16'h0000, 16'd16384);
    send_cmd(MODE_FOLLOW_YAW, 16'h7FFF, 16'h7FFF, 16'h0000, 16'd32768);
    send_cmd(MODE_FOLLOW_YAW, 16'h8000, 16'h7FFF, 16'h0000, 16'd49152);
    send_cmd(MODE_SPIN,       16'h0000, 16'h0000, 16'h0000, 16'd0);
    send_cmd(MODE_SPIN,       16'h7FFF, 16'h8000, 16'd12345, 16'hFFFF);
    send_cmd(MODE_ZERO_FORCE, 16'h0000, 16'h0000, 16'h7FFF, 16'd0);
    send_cmd(MODE_ZERO_FORCE, 16'h0000, 16'h0000, 16'h8000, 16'd8192);
    send_cmd(MODE_ZERO_FORCE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd24576);
    send_cmd(MODE_ZERO_FORCE, 16'h8000, 16'h8000, 16'h8000, 16'd40960);
    send_cmd(MODE_NO_FOLLOW,  16'd1000, 16'hFC18, 16'hFFFF, 16'd1);
    send_cmd(MODE_NO_FOLLOW,  16'hFFFF, 16'hFFFF, 16'h0000, 16'd16383);
    send_cmd(MODE_SPIN,       16'h8000, 16'h0000, 16'h0000, 16'd32767);
    send_cmd(MODE_FOLLOW_YAW, 16'h0000, 16'h7FFF, 16'h0000, 16'd49151);
    send_cmd(MODE_SPIN,       16'd12345, 16'hA460, 16'h8000, 16'd57344);

    for (int seg = 0; seg < 6; seg++) begin
      if (seg > 0) begin
        drain();
        case (seg)
          1: begin
            write_reg(CFG_SPIN_SPEED, 15'h7FFF);
            write_reg(CFG_POWER_GAIN, 15'd1023);
          end
          2: begin
            write_reg(CFG_SPIN_SPEED, 15'd0);
            write_reg(CFG_POWER_GAIN, 15'd0);
          end
          3: begin
            write_reg(CFG_SPIN_SPEED, 15'($urandom));
            write_reg(CFG_POWER_GAIN, 15'($urandom_range(1023)));
          end
          4: begin
            write_reg(CFG_SPIN_SPEED, 15'd1);
            write_reg(CFG_POWER_GAIN, 15'd256);
          end
          default: begin
            // upper data bits beyond the gain width are dropped
            write_reg(CFG_SPIN_SPEED, 15'($urandom));
            write_reg(CFG_POWER_GAIN, 15'($urandom));
          end
        endcase
      end
      case (seg / 2)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (SEGMENT_ITEMS) send_random();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mwm_pkg.sv
rtl/mwm_trig_rom.sv
rtl/mwm_rotate.sv
rtl/mwm_scale.sv
rtl/mecanum_wheel_mixer_top.sv
test/mecanum_wheel_mixer_checker.sv
test/mecanum_wheel_mixer_top_tb.sv
